// ----- rtl/terminal_input_event_decoder_unit_macros.svh -----
// Assertion helpers for the terminal input event decoder.
`ifndef TERMINAL_INPUT_EVENT_DECODER_UNIT_MACROS_SVH
`define TERMINAL_INPUT_EVENT_DECODER_UNIT_MACROS_SVH

// Implication checked at every rising clock edge, quiet during reset.
`define TIED_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked at every rising clock edge, quiet during reset.
`define TIED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tied_pkg.sv -----
package tied_pkg;

   localparam logic [2:0] MODE_GROUND    = 3'd0;
   localparam logic [2:0] MODE_ESC       = 3'd1;
   localparam logic [2:0] MODE_SS3       = 3'd2;
   localparam logic [2:0] MODE_CSI_ENTRY = 3'd3;
   localparam logic [2:0] MODE_CSI       = 3'd4;
   localparam logic [2:0] MODE_SGR       = 3'd5;
   localparam logic [2:0] MODE_X10       = 3'd6;
   localparam logic [2:0] MODE_UTF8      = 3'd7;

   localparam logic [5:0] K_UNKNOWN   = 6'd0;
   localparam logic [5:0] K_ENTER     = 6'd1;
   localparam logic [5:0] K_ESCAPE    = 6'd2;
   localparam logic [5:0] K_DELETE    = 6'd3;
   localparam logic [5:0] K_TAB       = 6'd4;
   localparam logic [5:0] K_SPACE     = 6'd5;
   localparam logic [5:0] K_BACKSPACE = 6'd6;
   localparam logic [5:0] K_UP        = 6'd7;
   localparam logic [5:0] K_DOWN      = 6'd8;
   localparam logic [5:0] K_LEFT      = 6'd9;
   localparam logic [5:0] K_RIGHT     = 6'd10;
   localparam logic [5:0] K_CHAR      = 6'd11;
   localparam logic [5:0] K_F1        = 6'd12;
   localparam logic [5:0] K_F2        = 6'd13;
   localparam logic [5:0] K_F3        = 6'd14;
   localparam logic [5:0] K_F4        = 6'd15;
   localparam logic [5:0] K_F13       = 6'd24;
   localparam logic [5:0] K_PAGE_UP   = 6'd47;
   localparam logic [5:0] K_PAGE_DOWN = 6'd48;
   localparam logic [5:0] K_INSERT    = 6'd49;
   localparam logic [5:0] K_END       = 6'd50;
   localparam logic [5:0] K_HOME      = 6'd51;

   localparam logic [7:0] MOD_SHIFT = 8'h01;
   localparam logic [7:0] MOD_ALT   = 8'h02;
   localparam logic [7:0] MOD_CTRL  = 8'h04;

   typedef struct packed {
      logic        event_kind;
      logic [5:0]  key_code;
      logic [20:0] char_code;
      logic [7:0]  modifier_bits;
      logic [2:0]  mouse_button;
      logic [20:0] mouse_col;
      logic [20:0] mouse_row;
   } event_type;

   // Key for the numeric code of a tilde sequence; zero means no event.
   function automatic logic [5:0] tilde_key(input logic [4:0] code);
      logic [5:0] k;
      begin
         case (code)
            5'd2:    k = K_INSERT;
            5'd3:    k = K_DELETE;
            5'd5:    k = K_PAGE_UP;
            5'd6:    k = K_PAGE_DOWN;
            5'd15:   k = 6'd16;
            5'd17:   k = 6'd17;
            5'd18:   k = 6'd18;
            5'd19:   k = 6'd19;
            5'd20:   k = 6'd20;
            5'd21:   k = 6'd21;
            5'd23:   k = 6'd22;
            5'd24:   k = 6'd23;
            5'd29:   k = 6'd52;
            default: k = K_UNKNOWN;
         endcase
         return k;
      end
   endfunction

   // Final letters shared by CSI and SS3; the flag is low for other bytes.
   function automatic logic [6:0] letter_key(input logic [7:0] b);
      logic [6:0] r;
      begin
         case (b)
            8'h41:   r = {1'b1, K_UP};
            8'h42:   r = {1'b1, K_DOWN};
            8'h43:   r = {1'b1, K_RIGHT};
            8'h44:   r = {1'b1, K_LEFT};
            8'h46:   r = {1'b1, K_END};
            8'h48:   r = {1'b1, K_HOME};
            8'h50:   r = {1'b1, K_F1};
            8'h51:   r = {1'b1, K_F2};
            8'h52:   r = {1'b1, K_F3};
            8'h53:   r = {1'b1, K_F4};
            default: r = {1'b0, K_UNKNOWN};
         endcase
         return r;
      end
   endfunction

   // Keypad characters for kitty codes 57409..57416.
   function automatic logic [7:0] pad_char(input logic [2:0] i);
      logic [7:0] c;
      begin
         case (i)
            3'd0:    c = 8'h2E;
            3'd1:    c = 8'h2F;
            3'd2:    c = 8'h2A;
            3'd3:    c = 8'h2D;
            3'd4:    c = 8'h2B;
            3'd6:    c = 8'h3D;
            3'd7:    c = 8'h2C;
            default: c = 8'h00;
         endcase
         return c;
      end
   endfunction

   // Keypad navigation keys for kitty codes 57417..57426.
   function automatic logic [5:0] pad_key(input logic [3:0] i);
      logic [5:0] k;
      begin
         case (i)
            4'd0:    k = K_LEFT;
            4'd1:    k = K_RIGHT;
            4'd2:    k = K_UP;
            4'd3:    k = K_DOWN;
            4'd4:    k = K_PAGE_UP;
            4'd5:    k = K_PAGE_DOWN;
            4'd6:    k = K_HOME;
            4'd7:    k = K_END;
            4'd8:    k = K_INSERT;
            4'd9:    k = K_DELETE;
            default: k = K_UNKNOWN;
         endcase
         return k;
      end
   endfunction

endpackage

// ----- rtl/terminal_input_event_decoder_unit.sv -----
// Terminal input event decoder.
//
// The req_ channel takes one raw terminal byte (req_rx_byte) per transaction.
// The rsp_ channel delivers decoded key or mouse events, one per transaction;
// a byte produces at most one event, on the byte that completes a sequence
// (plain byte, last UTF-8 byte, CSI/SS3 final byte, or mouse report end).
// Both channels use valid/stall: a transaction completes on a rising edge
// where valid is high and stall is low.
//
// Each byte is decoded by one pass of combinational logic (mode decode,
// one multiply-by-ten accumulate, table lookup) straight into the result
// register, so the block takes one byte per cycle and an event appears on
// rsp_ in the cycle after the byte that completes it. The result register and
// the parser state update together, so the sustained rate is one byte a cycle
// as long as the receiver takes events.
//
// While rsp_stall holds a waiting event, the block keeps accepting bytes that
// produce no event; a byte that would produce one is stalled on req_ until
// the result register frees. Synchronous reset returns the parser to ground
// mode with all parameters, the UTF-8 state and the result valid cleared.
`include "terminal_input_event_decoder_unit_macros.svh"

module terminal_input_event_decoder_unit
   import tied_pkg::*;
#(
   parameter int PARAM_BITS = 21
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_event_kind,
   output logic [5:0]  rsp_key_code,
   output logic [20:0] rsp_char_code,
   output logic [7:0]  rsp_modifier_bits,
   output logic [2:0]  rsp_mouse_button,
   output logic [20:0] rsp_mouse_col,
   output logic [20:0] rsp_mouse_row
);

   localparam logic [PARAM_BITS-1:0] LIMIT = {PARAM_BITS{1'b1}};
   localparam int PW = PARAM_BITS + 4;

   // Parser state.
   logic [2:0]            mode_ff, mode_in;
   logic [PARAM_BITS-1:0] acc_ff, acc_in;
   logic                  sub_ff, sub_in;
   logic [1:0]            total_ff, total_in;
   logic [PARAM_BITS-1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [1:0]            left_ff, left_in;
   logic [20:0]           cp_ff, cp_in;

   // Result register.
   logic      rv_ff, rv_in;
   event_type ev_ff, ev_in;

   logic      emit;
   event_type ev;
   logic      take, out_free;

   assign out_free  = !rv_ff || !rsp_stall;
   // A byte is held back only when it would produce an event with no room.
   assign req_stall = emit && !out_free;
   assign take      = req_valid && !req_stall;

   // Helpers on the incoming byte.
   logic [7:0] b;
   logic       is_digit;
   logic [PW-1:0] acc_next_wide;
   logic [PARAM_BITS-1:0] acc_sat;

   assign b        = req_rx_byte;
   assign is_digit = (b >= 8'h30) && (b <= 8'h39);
   assign acc_next_wide = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                          + PW'(b[3:0]);
   assign acc_sat = (acc_next_wide > PW'(LIMIT)) ? LIMIT : acc_next_wide[PARAM_BITS-1:0];

   // Effective parameters as seen after the terminating byte is stored.
   logic [PARAM_BITS-1:0] q0, q1, q2;
   logic [1:0]            n_fin;

   function automatic logic [20:0] m21(input logic [PARAM_BITS-1:0] v);
      logic [PARAM_BITS+20:0] w;
      begin
         w = {21'd0, v};
         return w[20:0];
      end
   endfunction

   always_comb begin
      q0 = p0_ff;
      q1 = p1_ff;
      q2 = p2_ff;
      if (!sub_ff) begin
         case (total_ff)
            2'd0:    q0 = acc_ff;
            2'd1:    q1 = acc_ff;
            2'd2:    q2 = acc_ff;
            default: q0 = p0_ff;
         endcase
      end
      n_fin = (total_ff == 2'd3) ? 2'd3 : total_ff + 2'd1;
   end

   // Mouse decode from the finished parameters.
   logic        mouse_ok;
   event_type   mouse_ev;
   logic [2:0]  bn;
   always_comb begin
      mouse_ev = '0;
      mouse_ev.event_kind = 1'b1;
      bn = 3'(({q0[7:6], 2'b00} | {2'b00, q0[1:0]}) & 4'h7);
      mouse_ok = (n_fin == 2'd3);
      case (bn)
         3'd0, 3'd1, 3'd2: mouse_ev.mouse_button = bn;
         3'd4:             mouse_ev.mouse_button = 3'd3;
         3'd5:             mouse_ev.mouse_button = 3'd4;
         default:          mouse_ok = 1'b0;
      endcase
      // Bit 7 of the mask is bit 3 of the button number, always out of range.
      if (q0[7]) mouse_ok = 1'b0;
      mouse_ev.modifier_bits = {5'd0, q0[4], q0[3], q0[2]};
      mouse_ev.mouse_col = m21(q1);
      mouse_ev.mouse_row = m21(q2);
   end

   // CSI final decode.
   logic        csi_ok;
   event_type   csi_ev;
   logic [7:0]  mods;
   logic [6:0]  lk;
   logic [PARAM_BITS-1:0] q1m;
   logic        own;
   always_comb begin
      csi_ev = '0;
      csi_ok = 1'b1;
      own    = 1'b0;
      q1m    = q1 - PARAM_BITS'(1);
      mods   = 8'd0;
      if (n_fin > 2'd1 && q1 != '0)
         mods = (q1m > PARAM_BITS'(255)) ? 8'd255 : q1m[7:0];
      lk = letter_key(b);
      if (lk[6]) begin
         csi_ev.key_code = lk[5:0];
      end else if (b == 8'h5A) begin
         csi_ev.key_code = K_TAB;
         own = 1'b1;
      end else if (b == 8'h7E) begin
         if (q0 >= PARAM_BITS'(30) || tilde_key(q0[4:0]) == K_UNKNOWN)
            csi_ok = 1'b0;
         else
            csi_ev.key_code = tilde_key(q0[4:0]);
      end else if (b == 8'h75) begin
         if (q0 == PARAM_BITS'(27))
            csi_ev.key_code = K_ESCAPE;
         else if (q0 == PARAM_BITS'(13) || q0 == PARAM_BITS'(10)
                  || q0 == PARAM_BITS'(57414))
            csi_ev.key_code = K_ENTER;
         else if (q0 == PARAM_BITS'(9))
            csi_ev.key_code = K_TAB;
         else if (q0 == PARAM_BITS'(8) || q0 == PARAM_BITS'(127))
            csi_ev.key_code = K_BACKSPACE;
         else if (q0 == PARAM_BITS'(32))
            csi_ev.key_code = K_SPACE;
         else if (q0 >= PARAM_BITS'(57399) && q0 <= PARAM_BITS'(57408)) begin
            csi_ev.key_code  = K_CHAR;
            csi_ev.char_code = 21'h30 + 21'(q0[3:0] - 4'(57399 % 16));
         end else if (q0 >= PARAM_BITS'(57409) && q0 <= PARAM_BITS'(57416)) begin
            csi_ev.key_code  = K_CHAR;
            csi_ev.char_code = {13'd0, pad_char(3'(q0[2:0] - 3'(57409 % 8)))};
         end else if (q0 >= PARAM_BITS'(57417) && q0 <= PARAM_BITS'(57426)) begin
            csi_ev.key_code = pad_key(4'(q0[5:0] - 6'(57417 % 64)));
         end else if (q0 >= PARAM_BITS'(57376) && q0 <= PARAM_BITS'(57398)) begin
            csi_ev.key_code = K_F13 + 6'(q0[5:0] - 6'(57376 % 64));
         end else if (q0 >= PARAM_BITS'(57344) && q0 <= PARAM_BITS'(63743)) begin
            csi_ev.key_code = K_UNKNOWN;
         end else begin
            csi_ev.key_code  = K_CHAR;
            csi_ev.char_code = m21(q0);
         end
      end else begin
         csi_ok = 1'b0;
      end
      csi_ev.modifier_bits = (mods != 8'd0) ? mods : {7'd0, own};
   end

   function automatic event_type key_ev(input logic [5:0] k, input logic [20:0] c,
                                        input logic [7:0] m);
      event_type e;
      begin
         e = '0;
         e.key_code = k;
         e.char_code = c;
         e.modifier_bits = m;
         return e;
      end
   endfunction

   function automatic event_type char_ev(input logic [20:0] c);
      begin
         return key_ev(K_CHAR, c, (c >= 21'h41 && c <= 21'h5A) ? MOD_SHIFT : 8'd0);
      end
   endfunction

   logic [20:0] cp_next;
   assign cp_next = {cp_ff[14:0], b[5:0]};

   // Next-state and event decode for one byte.
   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      sub_in   = sub_ff;
      total_in = total_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      left_in  = left_ff;
      cp_in    = cp_ff;
      emit = 1'b0;
      ev   = '0;
      case (mode_ff)
         MODE_ESC: begin
            if (b == 8'h5B) begin
               acc_in = '0; sub_in = 1'b0; total_in = 2'd0;
               p0_in = '0; p1_in = '0; p2_in = '0;
               mode_in = MODE_CSI_ENTRY;
            end else if (b == 8'h4F) begin
               mode_in = MODE_SS3;
            end else begin
               mode_in = MODE_GROUND;
            end
         end
         MODE_SS3: begin
            mode_in = MODE_GROUND;
            emit = lk[6];
            ev = key_ev(lk[5:0], 21'd0, 8'd0);
         end
         MODE_CSI_ENTRY, MODE_CSI, MODE_SGR, MODE_X10: begin
            if (mode_ff == MODE_CSI_ENTRY && b == 8'h3C) begin
               mode_in = MODE_SGR;
            end else if (mode_ff == MODE_CSI_ENTRY && b == 8'h4D) begin
               mode_in = MODE_X10;
            end else begin
               if (mode_ff == MODE_CSI_ENTRY) mode_in = MODE_CSI;
               if (is_digit) begin
                  acc_in = acc_sat;
               end else begin
                  acc_in = '0;
                  p0_in = q0; p1_in = q1; p2_in = q2;
                  if (total_ff == 2'd3) begin
                     p0_in = p0_ff;
                  end
                  if (b == 8'h3A) begin
                     sub_in = 1'b1;
                  end else begin
                     sub_in = 1'b0;
                     total_in = n_fin;
                     if (b != 8'h3B) begin
                        mode_in = MODE_GROUND;
                        if (mode_ff == MODE_SGR) begin
                           emit = (b == 8'h4D) && mouse_ok;
                           ev   = mouse_ev;
                        end else if (mode_ff == MODE_X10 || b == 8'h4D) begin
                           emit = mouse_ok;
                           ev   = mouse_ev;
                        end else begin
                           emit = csi_ok;
                           ev   = csi_ev;
                        end
                     end
                  end
               end
            end
         end
         MODE_UTF8: begin
            cp_in = cp_next;
            left_in = (left_ff != 2'd0) ? left_ff - 2'd1 : 2'd0;
            if (left_in == 2'd0) begin
               mode_in = MODE_GROUND;
               emit = 1'b1;
               ev = char_ev(cp_next);
            end
         end
         default: begin
            mode_in = MODE_GROUND;
            case (b)
               8'd0:  begin emit = 1'b1; ev = key_ev(K_SPACE, 21'd0, MOD_CTRL); end
               8'd13, 8'd10: begin emit = 1'b1; ev = key_ev(K_ENTER, 21'd0, 8'd0); end
               8'd9:  begin emit = 1'b1; ev = key_ev(K_TAB, 21'd0, 8'd0); end
               8'd8, 8'd127: begin
                  emit = 1'b1; ev = key_ev(K_BACKSPACE, 21'd0, 8'd0);
               end
               8'd32: begin emit = 1'b1; ev = key_ev(K_SPACE, 21'd0, 8'd0); end
               8'd27: mode_in = MODE_ESC;
               default: begin
                  if (b < 8'd27) begin
                     emit = 1'b1; ev = key_ev(K_CHAR, 21'(b) + 21'd96, MOD_CTRL);
                  end else if (b < 8'd32) begin
                     emit = 1'b1; ev = key_ev(K_CHAR, 21'(b) + 21'd64, MOD_CTRL);
                  end else if (b < 8'h80) begin
                     emit = 1'b1; ev = char_ev(21'(b));
                  end else if (b[7:5] == 3'b110) begin
                     cp_in = 21'(b[4:0]); left_in = 2'd1; mode_in = MODE_UTF8;
                  end else if (b[7:4] == 4'b1110) begin
                     cp_in = 21'(b[3:0]); left_in = 2'd2; mode_in = MODE_UTF8;
                  end else if (b[7:3] == 5'b11110) begin
                     cp_in = 21'(b[2:0]); left_in = 2'd3; mode_in = MODE_UTF8;
                  end
               end
            endcase
         end
      endcase
   end

   always_comb begin
      rv_in = rv_ff && rsp_stall;
      ev_in = ev_ff;
      if (take && emit) begin
         rv_in = 1'b1;
         ev_in = ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_GROUND;
         acc_ff   <= '0;
         sub_ff   <= 1'b0;
         total_ff <= 2'd0;
         p0_ff    <= '0;
         p1_ff    <= '0;
         p2_ff    <= '0;
         left_ff  <= 2'd0;
         cp_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         if (take) begin
            mode_ff  <= mode_in;
            acc_ff   <= acc_in;
            sub_ff   <= sub_in;
            total_ff <= total_in;
            p0_ff    <= p0_in;
            p1_ff    <= p1_in;
            p2_ff    <= p2_in;
            left_ff  <= left_in;
            cp_ff    <= cp_in;
         end
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff <= ev_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_event_kind    = ev_ff.event_kind;
   assign rsp_key_code      = ev_ff.key_code;
   assign rsp_char_code     = ev_ff.char_code;
   assign rsp_modifier_bits = ev_ff.modifier_bits;
   assign rsp_mouse_button  = ev_ff.mouse_button;
   assign rsp_mouse_col     = ev_ff.mouse_col;
   assign rsp_mouse_row     = ev_ff.mouse_row;

   `TIED_ASSERT_NEXT(a_event_held, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(ev_ff), "stalled event changed")
   `TIED_ASSERT_IMP(a_mouse_no_key, clock, reset, rsp_valid && rsp_event_kind,
      rsp_key_code == K_UNKNOWN, "mouse event carries a key code")
   `TIED_ASSERT_IMP(a_char_only, clock, reset,
      rsp_valid && rsp_key_code != K_CHAR, rsp_char_code == 21'd0,
      "char code without char key")
   `TIED_ASSERT_IMP(a_stall_only_full, clock, reset, req_stall,
      rsp_valid && rsp_stall, "input stalled with a free result register")

endmodule

// ----- tb/terminal_input_event_decoder_unit_tb.sv -----
module terminal_input_event_decoder_unit_tb;
   import tied_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Keypad menu key; the package stops short of naming it.
   localparam logic [5:0]  KEY_MENU    = 6'd52;
   localparam logic [20:0] PARAM_MAX   = 21'h1FFFFF;
   localparam int          ITEM_TARGET = 650;
   localparam int          QUIET_AFTER = 570;
   localparam int          HOLD_AFTER  = 200;
   localparam int          HOLD_CYCLES = 300;
   localparam int          STUCK_LIMIT = 2000;
   localparam logic [7:0]  BYTE_ESC    = 8'h1B;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_event_kind;
   logic [5:0]  rsp_key_code;
   logic [20:0] rsp_char_code;
   logic [7:0]  rsp_modifier_bits;
   logic [2:0]  rsp_mouse_button;
   logic [20:0] rsp_mouse_col;
   logic [20:0] rsp_mouse_row;

   terminal_input_event_decoder_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_event_kind(rsp_event_kind), .rsp_key_code(rsp_key_code),
      .rsp_char_code(rsp_char_code), .rsp_modifier_bits(rsp_modifier_bits),
      .rsp_mouse_button(rsp_mouse_button), .rsp_mouse_col(rsp_mouse_col),
      .rsp_mouse_row(rsp_mouse_row)
   );

   always #10 clock = ~clock;

   // Events the decoder owes us, oldest first.
   event_type pending_events[$];
   logic [7:0] byte_stream[$];
   int errors = 0;
   int bytes_sent = 0;
   int keys_seen = 0;
   int mice_seen = 0;
   int stuck_cycles = 0;
   bit quiet = 1'b0;

   // Shadow copy of the parser state, updated once per accepted byte.
   logic [2:0]  parse_mode = MODE_GROUND;
   logic [20:0] digits = '0;
   bit          sub_seen = 1'b0;
   logic [1:0]  param_count = '0;
   logic [20:0] params[3] = '{default: '0};
   logic [1:0]  utf8_left = '0;
   logic [20:0] codepoint = '0;

   // Appends one byte to the end of the outgoing stream.
   task automatic queue_byte(logic [7:0] v);
      byte_stream.insert(byte_stream.size(), v);
   endtask

   function automatic event_type key_event(logic [5:0] code, logic [20:0] ch,
                                           logic [7:0] mods);
      event_type e;
      e = '0;
      e.key_code = code;
      e.char_code = ch;
      e.modifier_bits = mods;
      return e;
   endfunction

   // Printable characters pick up shift when they are capital letters.
   function automatic event_type char_event(logic [20:0] cp);
      return key_event(K_CHAR, cp, (cp >= "A" && cp <= "Z") ? MOD_SHIFT : 8'h00);
   endfunction

   // Letters that end both CSI and SS3 sequences.
   function automatic bit letter_final(logic [7:0] b, output logic [5:0] code);
      code = K_UNKNOWN;
      case (b)
         "A": code = K_UP;
         "B": code = K_DOWN;
         "C": code = K_RIGHT;
         "D": code = K_LEFT;
         "F": code = K_END;
         "H": code = K_HOME;
         "P": code = K_F1;
         "Q": code = K_F2;
         "R": code = K_F3;
         "S": code = K_F4;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic logic [5:0] tilde_code(logic [20:0] p);
      case (p)
         21'd2:  return K_INSERT;
         21'd3:  return K_DELETE;
         21'd5:  return K_PAGE_UP;
         21'd6:  return K_PAGE_DOWN;
         21'd15: return K_F1 + 6'd4;
         21'd17, 21'd18, 21'd19, 21'd20, 21'd21: return p[5:0];
         21'd23: return 6'd22;
         21'd24: return 6'd23;
         21'd29: return KEY_MENU;
         default: return K_UNKNOWN;
      endcase
   endfunction

   // Kitty keyboard codes: plain keys, keypad digits and symbols, keypad
   // navigation, F13 and up, the rest of the private-use area, then text.
   function automatic logic [5:0] kitty_code(logic [20:0] p, output logic [20:0] ch);
      ch = '0;
      if (p == 21'd27) return K_ESCAPE;
      if (p == 21'd13 || p == 21'd10 || p == 21'd57414) return K_ENTER;
      if (p == 21'd9) return K_TAB;
      if (p == 21'd8 || p == 21'd127) return K_BACKSPACE;
      if (p == 21'd32) return K_SPACE;
      if (p >= 21'd57399 && p <= 21'd57408) begin
         ch = 21'h30 + (p - 21'd57399);
         return K_CHAR;
      end
      if (p >= 21'd57409 && p <= 21'd57416) begin
         case (p - 21'd57409)
            21'd0: ch = ".";
            21'd1: ch = "/";
            21'd2: ch = "*";
            21'd3: ch = "-";
            21'd4: ch = "+";
            21'd6: ch = "=";
            21'd7: ch = ",";
            default: ch = '0;
         endcase
         return K_CHAR;
      end
      if (p >= 21'd57417 && p <= 21'd57426) begin
         case (p - 21'd57417)
            21'd0: return K_LEFT;
            21'd1: return K_RIGHT;
            21'd2: return K_UP;
            21'd3: return K_DOWN;
            21'd4: return K_PAGE_UP;
            21'd5: return K_PAGE_DOWN;
            21'd6: return K_HOME;
            21'd7: return K_END;
            21'd8: return K_INSERT;
            default: return K_DELETE;
         endcase
      end
      if (p >= 21'd57376 && p <= 21'd57398) return K_F13 + 6'(p - 21'd57376);
      if (p >= 21'd57344 && p <= 21'd63743) return K_UNKNOWN;
      ch = p;
      return K_CHAR;
   endfunction

   // Returns 0 while the byte is still inside the parameter list, else the
   // number of parameters seen (1 to 3).
   function automatic int param_step(logic [7:0] b);
      logic [35:0] wide;
      if (b >= "0" && b <= "9") begin
         wide = 36'(digits) * 36'd10 + 36'(b - 8'h30);
         digits = (wide > 36'(PARAM_MAX)) ? PARAM_MAX : wide[20:0];
         return 0;
      end
      if (!sub_seen && param_count < 2'd3) params[param_count] = digits;
      digits = '0;
      if (b == ":") begin
         sub_seen = 1'b1;
         return 0;
      end
      sub_seen = 1'b0;
      if (param_count < 2'd3) param_count++;
      if (b == ";") return 0;
      return int'(param_count);
   endfunction

   function automatic bit mouse_report(int n, output event_type e);
      logic [20:0] m;
      logic [3:0]  bn;
      e = '0;
      if (n < 3) return 1'b0;
      m = params[0];
      bn = {m[7:6], m[1:0]};
      case (bn)
         4'd0, 4'd1, 4'd2: e.mouse_button = bn[2:0];
         4'd4: e.mouse_button = 3'd3;
         4'd5: e.mouse_button = 3'd4;
         default: return 1'b0;
      endcase
      e.event_kind = 1'b1;
      e.modifier_bits = {5'b0, m[4], m[3], m[2]};
      e.mouse_col = params[1];
      e.mouse_row = params[2];
      return 1'b1;
   endfunction

   function automatic bit csi_final(logic [7:0] b, int n, output event_type e);
      logic [7:0]  mods;
      logic [7:0]  own;
      logic [5:0]  code;
      logic [20:0] ch;
      e = '0;
      mods = '0;
      own = '0;
      ch = '0;
      // A modifier parameter above one overrides the key's own bits.
      if (n > 1 && params[1] > 0)
         mods = (params[1] - 21'd1 > 21'd255) ? 8'hFF : 8'(params[1] - 21'd1);
      if (b == "M") return mouse_report(n, e);
      if (!letter_final(b, code)) begin
         case (b)
            "Z": begin
               code = K_TAB;
               own = MOD_SHIFT;
            end
            "~": begin
               code = tilde_code(params[0]);
               if (code == K_UNKNOWN) return 1'b0;
            end
            "u": code = kitty_code(params[0], ch);
            default: return 1'b0;
         endcase
      end
      e = key_event(code, ch, (mods != 0) ? mods : own);
      return 1'b1;
   endfunction

   function automatic bit ground_byte(logic [7:0] b, output event_type e);
      e = '0;
      case (b)
         8'h00: e = key_event(K_SPACE, '0, MOD_CTRL);
         8'h0D, 8'h0A: e = key_event(K_ENTER, '0, '0);
         8'h09: e = key_event(K_TAB, '0, '0);
         8'h08, 8'h7F: e = key_event(K_BACKSPACE, '0, '0);
         8'h20: e = key_event(K_SPACE, '0, '0);
         BYTE_ESC: begin
            parse_mode = MODE_ESC;
            return 1'b0;
         end
         default: begin
            if (b < 8'd27) e = key_event(K_CHAR, 21'(b) + 21'd96, MOD_CTRL);
            else if (b < 8'd32) e = key_event(K_CHAR, 21'(b) + 21'd64, MOD_CTRL);
            else if (b < 8'h80) e = char_event(21'(b));
            else begin
               if (b[7:5] == 3'b110) begin
                  codepoint = 21'(b[4:0]);
                  utf8_left = 2'd1;
               end else if (b[7:4] == 4'b1110) begin
                  codepoint = 21'(b[3:0]);
                  utf8_left = 2'd2;
               end else if (b[7:3] == 5'b11110) begin
                  codepoint = 21'(b[2:0]);
                  utf8_left = 2'd3;
               end else begin
                  return 1'b0;
               end
               parse_mode = MODE_UTF8;
               return 1'b0;
            end
         end
      endcase
      return 1'b1;
   endfunction

   // Advances the shadow parser by one byte; returns 1 with the event it owes.
   function automatic bit decode_byte(logic [7:0] b, output event_type e);
      int n;
      logic [5:0] code;
      e = '0;
      case (parse_mode)
         MODE_ESC: begin
            if (b == "[") begin
               digits = '0;
               sub_seen = 1'b0;
               param_count = '0;
               params = '{default: '0};
               parse_mode = MODE_CSI_ENTRY;
            end else if (b == "O") begin
               parse_mode = MODE_SS3;
            end else begin
               parse_mode = MODE_GROUND;
            end
            return 1'b0;
         end
         MODE_SS3: begin
            parse_mode = MODE_GROUND;
            if (!letter_final(b, code)) return 1'b0;
            e = key_event(code, '0, '0);
            return 1'b1;
         end
         MODE_CSI_ENTRY, MODE_CSI: begin
            if (parse_mode == MODE_CSI_ENTRY && b == "<") begin
               parse_mode = MODE_SGR;
               return 1'b0;
            end
            if (parse_mode == MODE_CSI_ENTRY && b == "M") begin
               parse_mode = MODE_X10;
               return 1'b0;
            end
            parse_mode = MODE_CSI;
            n = param_step(b);
            if (n == 0) return 1'b0;
            parse_mode = MODE_GROUND;
            return csi_final(b, n, e);
         end
         MODE_SGR, MODE_X10: begin
            n = param_step(b);
            if (n == 0) return 1'b0;
            // SGR reports only count when pressed ('M'); legacy takes any end.
            if (parse_mode == MODE_SGR && b != "M") begin
               parse_mode = MODE_GROUND;
               return 1'b0;
            end
            parse_mode = MODE_GROUND;
            return mouse_report(n, e);
         end
         MODE_UTF8: begin
            codepoint = {codepoint[14:0], b[5:0]};
            if (utf8_left > 0) utf8_left--;
            if (utf8_left != 0) return 1'b0;
            parse_mode = MODE_GROUND;
            e = char_event(codepoint);
            return 1'b1;
         end
         default: begin
            parse_mode = MODE_GROUND;
            return ground_byte(b, e);
         end
      endcase
   endfunction

   // Directed opening. Rows with a typed event are checked against it; the
   // others rely on the shadow parser.
   typedef struct {
      logic [7:0] rx;
      bit         typed;
      event_type  ev;
   } opening_row;

   opening_row opening[24] = '{
      '{8'h00, 1'b1, '{1'b0, K_SPACE, 21'd0, MOD_CTRL, 3'd0, 21'd0, 21'd0}},
      '{8'h0D, 1'b1, '{1'b0, K_ENTER, 21'd0, 8'h00, 3'd0, 21'd0, 21'd0}},
      '{8'h7F, 1'b1, '{1'b0, K_BACKSPACE, 21'd0, 8'h00, 3'd0, 21'd0, 21'd0}},
      '{8'h01, 1'b1, '{1'b0, K_CHAR, 21'd97, MOD_CTRL, 3'd0, 21'd0, 21'd0}},
      '{8'h41, 1'b1, '{1'b0, K_CHAR, 21'd65, MOD_SHIFT, 3'd0, 21'd0, 21'd0}},
      '{8'hFF, 1'b0, '0},
      '{8'h1B, 1'b0, '0}, '{8'h5B, 1'b0, '0}, '{8'h5A, 1'b0, '0},
      '{8'h1B, 1'b0, '0}, '{8'h4F, 1'b0, '0}, '{8'h50, 1'b0, '0},
      '{8'h1B, 1'b0, '0}, '{8'h5B, 1'b0, '0}, '{8'h3C, 1'b0, '0},
      '{8'h36, 1'b0, '0}, '{8'h34, 1'b0, '0}, '{8'h3B, 1'b0, '0},
      '{8'h39, 1'b0, '0}, '{8'h3B, 1'b0, '0}, '{8'h39, 1'b0, '0},
      '{8'h4D, 1'b0, '0},
      '{8'hC3, 1'b0, '0}, '{8'hA9, 1'b0, '0}
   };

   // Offers one byte, waits for the decoder to take it and records the event
   // it should cause. Stall is sampled at the falling edge, where it already
   // holds the value the next rising edge will see.
   task automatic offer_byte(logic [7:0] b, bit typed, event_type typed_ev);
      event_type e;
      bit owed;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(negedge clock); while (req_stall);
      owed = decode_byte(b, e);
      if (typed) begin
         owed = 1'b1;
         e = typed_ev;
      end
      if (owed) pending_events.insert(pending_events.size(), e);
      bytes_sent++;
      quiet = (bytes_sent >= QUIET_AFTER);
      @(posedge clock);
   endtask

   task automatic push_number(int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      foreach (s[i]) queue_byte(s[i]);
   endtask

   // Parameter values lean on the interesting ranges: tilde and modifier
   // codes, the kitty private-use block and values that saturate.
   function automatic int unsigned pick_param();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 9);
         1: return $urandom_range(0, 35);
         2: return $urandom_range(57344, 57430);
         3: return $urandom_range(57344, 63743);
         4: return $urandom_range(0, 2097151);
         default: return $urandom_range(2097150, 99999999);
      endcase
   endfunction

   function automatic int unsigned pick_button_mask();
      int unsigned base;
      case ($urandom_range(0, 3))
         0: base = $urandom_range(0, 2);
         1: base = 64 + $urandom_range(0, 3);
         2: base = $urandom_range(0, 255);
         default: base = $urandom_range(0, 7);
      endcase
      return base | ($urandom_range(0, 7) << 2);
   endfunction

   // Appends one sequence to the byte stream. Most are well formed with
   // random content; the rest are noise and broken escapes.
   task automatic build_sequence();
      string finals;
      int np;
      finals = "ABCDFHPQRSZ~uMu~";
      case ($urandom_range(0, 11))
         0, 1: repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
         2: queue_byte(8'($urandom_range(0, 127)));
         3: begin
            np = $urandom_range(1, 3);
            case (np)
               1: queue_byte(8'($urandom_range(8'hC0, 8'hDF)));
               2: queue_byte(8'($urandom_range(8'hE0, 8'hEF)));
               default: queue_byte(8'($urandom_range(8'hF0, 8'hF7)));
            endcase
            repeat (np) queue_byte(8'($urandom_range(0, 255)));
         end
         4, 5, 6: begin
            queue_byte(BYTE_ESC);
            queue_byte("[");
            np = $urandom_range(0, 4);
            for (int i = 0; i < np; i++) begin
               if (i > 0) queue_byte(";");
               if ($urandom_range(0, 5) != 0) push_number(pick_param());
               if ($urandom_range(0, 6) == 0) begin
                  queue_byte(":");
                  push_number(pick_param());
               end
            end
            if ($urandom_range(0, 7) == 0)
               queue_byte(8'($urandom_range(8'h20, 8'h7E)));
            else
               queue_byte(finals[$urandom_range(0, finals.len() - 1)]);
         end
         7, 8: begin
            queue_byte(BYTE_ESC);
            queue_byte("[");
            queue_byte(($urandom_range(0, 1) == 0) ? "<" : "M");
            push_number(pick_button_mask());
            queue_byte(";");
            push_number($urandom_range(0, 3) == 0 ? pick_param() : $urandom_range(1, 300));
            if ($urandom_range(0, 5) != 0) begin
               queue_byte(";");
               push_number($urandom_range(0, 3) == 0 ? pick_param() : $urandom_range(1, 200));
            end
            case ($urandom_range(0, 5))
               0: queue_byte("m");
               1: queue_byte(8'($urandom_range(8'h40, 8'h7E)));
               default: queue_byte("M");
            endcase
         end
         9, 10: begin
            queue_byte(BYTE_ESC);
            queue_byte("O");
            queue_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                       : finals[$urandom_range(0, 9)]);
         end
         default: begin
            queue_byte(BYTE_ESC);
            queue_byte(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   // Stimulus: reset, the directed opening, then random sequences.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (opening[i]) offer_byte(opening[i].rx, opening[i].typed, opening[i].ev);
      while (bytes_sent < ITEM_TARGET) begin
         build_sequence();
         while (byte_stream.size() > 0) offer_byte(byte_stream.pop_front(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (pending_events.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Decoded %0d bytes into %0d key and %0d mouse events,", bytes_sent,
               keys_seen, mice_seen);
      $display("including a long result stall that backed up the byte input.");
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Receiver: random stall bursts, one long hold-off once the run is under
   // way, and a steady tail with no stalls at all.
   initial begin
      bit held;
      held = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!held && bytes_sent >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Result checking and the watchdog. Everything is sampled at the falling
   // edge, between the rising edges at which inputs change.
   always @(negedge clock) begin
      event_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               $display("%0t: unexpected event kind=%0d key=%0d char=%0h", $time,
                        rsp_event_kind, rsp_key_code, rsp_char_code);
               errors++;
            end else begin
               want = pending_events.pop_front();
               if (rsp_event_kind) mice_seen++; else keys_seen++;
               if (rsp_event_kind !== want.event_kind) begin
                  $display("%0t: event_kind expected %0d got %0d", $time,
                           want.event_kind, rsp_event_kind);
                  errors++;
               end
               if (rsp_key_code !== want.key_code) begin
                  $display("%0t: key_code expected %0d got %0d", $time,
                           want.key_code, rsp_key_code);
                  errors++;
               end
               if (rsp_char_code !== want.char_code) begin
                  $display("%0t: char_code expected %0h got %0h", $time,
                           want.char_code, rsp_char_code);
                  errors++;
               end
               if (rsp_modifier_bits !== want.modifier_bits) begin
                  $display("%0t: modifier_bits expected %0h got %0h", $time,
                           want.modifier_bits, rsp_modifier_bits);
                  errors++;
               end
               if (rsp_mouse_button !== want.mouse_button) begin
                  $display("%0t: mouse_button expected %0d got %0d", $time,
                           want.mouse_button, rsp_mouse_button);
                  errors++;
               end
               if (rsp_mouse_col !== want.mouse_col) begin
                  $display("%0t: mouse_col expected %0d got %0d", $time,
                           want.mouse_col, rsp_mouse_col);
                  errors++;
               end
               if (rsp_mouse_row !== want.mouse_row) begin
                  $display("%0t: mouse_row expected %0d got %0d", $time,
                           want.mouse_row, rsp_mouse_row);
                  errors++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
         end
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d events still owed", $time,
                     stuck_cycles, pending_events.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule
